// ===== rtl/bdm_pkg.sv =====
// Package for the button debouncer with multi-press and long-press counting.
// Beat structs, configuration struct and register index codes; no dependencies.
`default_nettype none
package bdm_pkg;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_ACTIVE_HIGH    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_ENABLE         = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_DEBOUNCE_MS    = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_MULTI_PRESS_MS = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_LONG_PRESS_MS  = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_BUTTON_VALUE   = 3'd5;

  localparam logic [15:0] DEBOUNCE_MS_RST    = 16'd20;
  localparam logic [15:0] MULTI_PRESS_MS_RST = 16'd250;
  localparam logic [15:0] LONG_PRESS_MS_RST  = 16'd1000;

  localparam logic       FUNC_SAMPLE      = 1'b0;
  localparam logic       FUNC_SET_PRESSES = 1'b1;
  localparam logic [7:0] COUNT_MAX        = 8'd255;

  typedef struct packed {
    logic               func;
    logic        [31:0] sample_time;
    logic               pin_level;
    logic signed [15:0] new_presses;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] presses;
    logic               held;
    logic               depressed;
    logic signed [15:0] press_value;
  } out_beat_t;

  typedef struct packed {
    logic               active_high;
    logic               enable;
    logic        [15:0] debounce_ms;
    logic        [15:0] multi_press_ms;
    logic        [15:0] long_press_ms;
    logic signed [15:0] button_value;
  } cfg_t;

  // State shown to the output stage after a beat has been applied.
  typedef struct packed {
    logic signed [15:0] presses;
    logic               held;
    logic               depressed;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/button_debounce_multipress.sv =====
// Top level of the button debouncer with multi-press and long-press reporting.
// Depends on bdm_pkg, bdm_core and bdm_out.
//
// Each input beat is either a timestamped pin sample or a set-presses command,
// and each one yields exactly one result beat. A beat is taken every cycle as
// long as the result side keeps up; a result passes first through the state
// update register and then through the press value multiply and result
// register. The state update (32-bit elapsed-time subtract and three compares)
// sets the single-cycle throughput. The user writes the configuration
// registers through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block does not enforce it. Indexes past the register list are ignored.
`default_nettype none
module button_debounce_multipress (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire bdm_pkg::in_beat_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output bdm_pkg::out_beat_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [bdm_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [bdm_pkg::CfgDataW-1:0]    cfg_data
);
  import bdm_pkg::*;

  cfg_t    cfg;
  logic    st_valid;
  logic    st_ready;
  status_t st_data;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high    <= 1'b0;
      cfg.enable         <= 1'b1;
      cfg.debounce_ms    <= DEBOUNCE_MS_RST;
      cfg.multi_press_ms <= MULTI_PRESS_MS_RST;
      cfg.long_press_ms  <= LONG_PRESS_MS_RST;
      cfg.button_value   <= 16'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_HIGH:    cfg.active_high    <= cfg_data[0];
        REG_ENABLE:         cfg.enable         <= cfg_data[0];
        REG_DEBOUNCE_MS:    cfg.debounce_ms    <= cfg_data;
        REG_MULTI_PRESS_MS: cfg.multi_press_ms <= cfg_data;
        REG_LONG_PRESS_MS:  cfg.long_press_ms  <= cfg_data;
        REG_BUTTON_VALUE:   cfg.button_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  // state update: debounce timer, press counter, long press
  bdm_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st_data  (st_data)
  );

  // press value multiply and result register
  bdm_out u_out (
    .clk          (clk),
    .rst          (rst),
    .button_value (cfg.button_value),
    .st_valid     (st_valid),
    .st_ready     (st_ready),
    .st_data      (st_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/bdm_core.sv =====
// Debounce and press-count state update, one input beat per cycle
// while the output stage takes each result. Depends on bdm_pkg.
`default_nettype none
module bdm_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bdm_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bdm_pkg::in_beat_t in_data,
  output logic                  st_valid,
  input  wire logic             st_ready,
  output bdm_pkg::status_t      st_data
);
  import bdm_pkg::*;

  logic        last_level, last_level_next;
  logic [31:0] last_change_time, last_change_time_next;
  logic        debounced, debounced_next;
  logic [7:0]  press_counter, press_counter_next;
  logic [15:0] press_total, press_total_next;
  logic        long_flag, long_flag_next;

  logic        level;
  logic [31:0] elapsed;
  logic        accept;

  assign in_ready = !st_valid || st_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    last_level_next       = last_level;
    last_change_time_next = last_change_time;
    debounced_next        = debounced;
    press_counter_next    = press_counter;
    press_total_next      = press_total;
    long_flag_next        = long_flag;
    level   = cfg.active_high ? in_data.pin_level : !in_data.pin_level;
    elapsed = 32'd0;
    if (in_data.func == FUNC_SET_PRESSES) begin
      press_total_next      = in_data.new_presses;
      press_counter_next    = 8'd0;
      last_level_next       = !cfg.active_high;
      last_change_time_next = 32'd0;
    end else if (cfg.enable) begin
      long_flag_next = 1'b0;
      if (level != last_level) begin
        last_change_time_next = in_data.sample_time;
      end
      elapsed = in_data.sample_time - last_change_time_next;
      if (elapsed > {16'd0, cfg.debounce_ms} && level != debounced) begin
        debounced_next = level;
        if (level && press_counter != COUNT_MAX) begin
          press_counter_next = press_counter + 8'd1;
        end
      end
      if (!debounced_next && elapsed > {16'd0, cfg.multi_press_ms}) begin
        press_total_next   = {8'd0, press_counter_next};
        press_counter_next = 8'd0;
      end
      if (debounced_next && elapsed > {16'd0, cfg.long_press_ms}) begin
        long_flag_next     = 1'b1;
        press_total_next   = 16'd0 - {8'd0, press_counter_next};
        press_counter_next = 8'd0;
      end
      last_level_next = level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level       <= 1'b1;
      last_change_time <= 32'd0;
      debounced        <= 1'b0;
      press_counter    <= 8'd0;
      press_total      <= 16'd0;
      long_flag        <= 1'b0;
      st_valid         <= 1'b0;
    end else begin
      if (accept) begin
        last_level       <= last_level_next;
        last_change_time <= last_change_time_next;
        debounced        <= debounced_next;
        press_counter    <= press_counter_next;
        press_total      <= press_total_next;
        long_flag        <= long_flag_next;
        st_valid         <= 1'b1;
      end else if (st_ready) begin
        st_valid <= 1'b0;
      end
    end
  end

  assign st_data.presses   = press_total;
  assign st_data.held      = long_flag;
  assign st_data.depressed = debounced;

endmodule
`default_nettype wire

// ===== rtl/bdm_out.sv =====
// Output stage: press value multiply and result register.
// Depends on bdm_pkg.
`default_nettype none
module bdm_out (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [15:0] button_value,
  input  wire logic               st_valid,
  output logic                    st_ready,
  input  wire bdm_pkg::status_t   st_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bdm_pkg::out_beat_t      out_data
);
  import bdm_pkg::*;

  logic [31:0] prod;

  // low 16 bits are the same for signed and unsigned operands
  assign prod     = {16'd0, button_value} * {16'd0, st_data.presses};
  assign st_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_ready) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid && st_ready) begin
      out_data.presses     <= st_data.presses;
      out_data.held        <= st_data.held;
      out_data.depressed   <= st_data.depressed;
      out_data.press_value <= prod[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bdm_checker.sv =====
// Port-level checks for button_debounce_multipress, bound to the top level.
// Depends on bdm_pkg.
`default_nettype none
module bdm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bdm_pkg::out_beat_t out_data
);
  import bdm_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a presented result carries no unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown(out_data))
    else $error("result with unknown bits");

  // a long press is only reported while pressed
  a_held_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.held |-> out_data.depressed)
    else $error("held without depressed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_debounce_multipress bdm_checker u_bdm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/sv/press_report_checker.sv =====
// Checker for button_debounce_multipress: mirrors the register file and the
// debounce / press-count state, predicts one report per input beat, compares.
// Depends on bdm_pkg.
module press_report_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  bdm_pkg::in_beat_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  bdm_pkg::out_beat_t            out_data,
  input  logic                          cfg_we,
  input  logic [bdm_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [bdm_pkg::CfgDataW-1:0]  cfg_data,
  output int                            fail_count,
  output int                            compared,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdm_pkg::*;

  cfg_t        regs;
  logic        prev_level;
  logic        stable_level;
  logic        long_seen;
  logic [31:0] change_stamp;
  logic [7:0]  run_count;
  logic [15:0] report_presses;
  out_beat_t   expected_reports [$];

  assign pending = expected_reports.size();

  always @(posedge clk) begin
    out_beat_t   want;
    logic        level;
    logic [31:0] elapsed;
    logic [31:0] product;
    if (rst) begin
      regs.active_high    = 1'b0;
      regs.enable         = 1'b1;
      regs.debounce_ms    = DEBOUNCE_MS_RST;
      regs.multi_press_ms = MULTI_PRESS_MS_RST;
      regs.long_press_ms  = LONG_PRESS_MS_RST;
      regs.button_value   = '0;
      prev_level          = 1'b1;
      change_stamp        = '0;
      stable_level        = 1'b0;
      run_count           = '0;
      report_presses      = '0;
      long_seen           = 1'b0;
      expected_reports.delete();
      fail_count          = 0;
      compared            = 0;
    end else begin
      // Report side first: a report leaving now belongs to an older beat.
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report beat with none expected: presses %0d", out_data.presses);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          compared++;
          if (out_data.presses !== want.presses) begin
            $error("presses: expected %0d, got %0d", want.presses, out_data.presses);
            fail_count++;
          end
          if (out_data.held !== want.held) begin
            $error("held: expected %0b, got %0b", want.held, out_data.held);
            fail_count++;
          end
          if (out_data.depressed !== want.depressed) begin
            $error("depressed: expected %0b, got %0b", want.depressed, out_data.depressed);
            fail_count++;
          end
          if (out_data.press_value !== want.press_value) begin
            $error("press_value: expected %0d, got %0d", want.press_value,
                   out_data.press_value);
            fail_count++;
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_HIGH:    regs.active_high    = cfg_data[0];
          REG_ENABLE:         regs.enable         = cfg_data[0];
          REG_DEBOUNCE_MS:    regs.debounce_ms    = cfg_data;
          REG_MULTI_PRESS_MS: regs.multi_press_ms = cfg_data;
          REG_LONG_PRESS_MS:  regs.long_press_ms  = cfg_data;
          REG_BUTTON_VALUE:   regs.button_value   = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_SET_PRESSES) begin
          // Works even when disabled; debounced and held stay as they are.
          report_presses = in_data.new_presses;
          run_count      = '0;
          prev_level     = ~regs.active_high;
          change_stamp   = '0;
        end else if (regs.enable) begin
          level     = regs.active_high ? in_data.pin_level : ~in_data.pin_level;
          long_seen = 1'b0;
          if (level != prev_level) change_stamp = in_data.sample_time;
          elapsed = in_data.sample_time - change_stamp;
          if (elapsed > {16'd0, regs.debounce_ms} && level != stable_level) begin
            stable_level = level;
            if (stable_level && run_count < COUNT_MAX) run_count = run_count + 8'd1;
          end
          if (!stable_level && elapsed > {16'd0, regs.multi_press_ms}) begin
            report_presses = {8'd0, run_count};
            run_count      = '0;
          end
          if (stable_level && elapsed > {16'd0, regs.long_press_ms}) begin
            long_seen      = 1'b1;
            report_presses = 16'd0 - {8'd0, run_count};
            run_count      = '0;
          end
          prev_level = level;
        end
        product          = {16'd0, regs.button_value} * {16'd0, report_presses};
        want.presses     = report_presses;
        want.held        = long_seen;
        want.depressed   = stable_level;
        want.press_value = product[15:0];
        expected_reports.push_back(want);
      end
    end
  end

endmodule

// ===== tb/sv/button_debounce_multipress_tb.sv =====
// Top of the button_debounce_multipress testbench: clock, reset, stimulus and
// verdict. Depends on bdm_pkg, the block and press_report_checker.
module button_debounce_multipress_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdm_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  int          fail_count;
  int          compared;
  int          pending;       // reports predicted but not yet seen
  cfg_t        cur;           // register values the block holds right now
  logic [31:0] now;           // running millisecond timestamp
  int          beats_sent   = 0;
  int          settings_done = 0;
  bit          idle_on      = 1'b1;
  int          stall_left   = 0;

  always #6 clk = ~clk;

  button_debounce_multipress uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  press_report_checker report_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .compared   (compared),
    .pending    (pending)
  );

  // Report side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one beat and hold it until the block takes it. An optional gap
  // of idle cycles goes in front while idling is on.
  task automatic send_beat(input in_beat_t b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Pin sample dt ms after the previous one. The pin is driven with the
  // polarity the block is set to, so "pressed" means pressed.
  task automatic pin_sample(input logic pressed, input logic [31:0] dt);
    in_beat_t b;
    now           = now + dt;
    b.func        = FUNC_SAMPLE;
    b.sample_time = now;
    b.pin_level   = cur.active_high ? pressed : ~pressed;
    b.new_presses = 16'($urandom());   // ignored on samples, toggled anyway
    send_beat(b);
  endtask

  task automatic set_presses(input logic [15:0] value, input logic [31:0] stamp);
    in_beat_t b;
    b.func        = FUNC_SET_PRESSES;
    b.sample_time = stamp;
    b.pin_level   = 1'($urandom_range(0, 1));
    b.new_presses = value;
    send_beat(b);
  endtask

  // Gap short enough that a level cannot debounce.
  function automatic logic [31:0] short_dt();
    return $urandom_range(32'(cur.debounce_ms), 0);
  endfunction

  // Stop sending and wait until every predicted report is out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all registers with the block idle. Indexes 6 and 7 lie past the
  // register list; they get random data that the block must ignore.
  task automatic apply_cfg(input cfg_t c);
    logic [CfgIndexW-1:0] sel;
    drain();
    for (int i = 0; i < 8; i++) begin
      sel       = i[CfgIndexW-1:0];
      cfg_we    <= 1'b1;
      cfg_index <= sel;
      case (sel)
        REG_ACTIVE_HIGH:    cfg_data <= {15'd0, c.active_high};
        REG_ENABLE:         cfg_data <= {15'd0, c.enable};
        REG_DEBOUNCE_MS:    cfg_data <= c.debounce_ms;
        REG_MULTI_PRESS_MS: cfg_data <= c.multi_press_ms;
        REG_LONG_PRESS_MS:  cfg_data <= c.long_press_ms;
        REG_BUTTON_VALUE:   cfg_data <= c.button_value;
        default:            cfg_data <= 16'($urandom());
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = c;
    settings_done++;
  endtask

  // Move to a level with some contact bounce first, then hold it for `hold`.
  task automatic settle(input logic pressed, input logic [31:0] hold);
    int bounces;
    bounces = $urandom_range(0, 2);
    repeat (bounces) begin
      pin_sample(pressed, short_dt());
      pin_sample(~pressed, short_dt());
    end
    pin_sample(pressed, short_dt());
    pin_sample(pressed, hold);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t c;
    c.active_high    = 1'($urandom_range(0, 1));
    c.enable         = ($urandom_range(0, 3) != 0);
    c.debounce_ms    = 16'($urandom_range(0, 40));
    c.multi_press_ms = 16'($urandom_range(0, 400));
    c.long_press_ms  = 16'($urandom_range(0, 1500));
    c.button_value   = 16'($urandom());
    return c;
  endfunction

  // One register setting, then random gestures until `count` beats went out.
  // Mostly clean multi-click and long-hold gestures timed against the
  // current thresholds; the rest is set-presses and raw pin noise.
  task automatic run_phase(input cfg_t c, input int count);
    int          stop_at;
    int          pick;
    logic [31:0] db;
    logic [31:0] mp;
    logic [31:0] lp;
    apply_cfg(c);
    db      = 32'(c.debounce_ms);
    mp      = 32'(c.multi_press_ms);
    lp      = 32'(c.long_press_ms);
    now     = $urandom();   // start anywhere on the 32-bit time line
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        // click burst, then a long release that publishes the count
        repeat ($urandom_range(1, 4)) begin
          settle(1'b1, db + 1 + $urandom_range(0, 15));
          settle(1'b0, db + 1 + $urandom_range(0, 15));
        end
        pin_sample(1'b0, mp + 1 + $urandom_range(0, 40));
      end else if (pick < 8) begin
        // long hold, keep holding a bit, then let go
        settle(1'b1, lp + 1 + $urandom_range(0, 200));
        pin_sample(1'b1, $urandom_range(0, 500));
        settle(1'b0, mp + 1 + $urandom_range(0, 40));
      end else if (pick == 8) begin
        set_presses(16'($urandom()), $urandom());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0:       pin_sample(1'($urandom_range(0, 1)), short_dt());
            1:       pin_sample(1'($urandom_range(0, 1)), $urandom_range(0, 3000));
            default: pin_sample(1'($urandom_range(0, 1)), $urandom());
          endcase
        end
      end
    end
  endtask

  initial begin
    cfg_t c;
    bit   leftover;
    leftover = 1'b0;

    cur.active_high    = 1'b0;
    cur.enable         = 1'b1;
    cur.debounce_ms    = DEBOUNCE_MS_RST;
    cur.multi_press_ms = MULTI_PRESS_MS_RST;
    cur.long_press_ms  = LONG_PRESS_MS_RST;
    cur.button_value   = '0;
    now                = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Reset settings: set-presses extremes, timestamps at both ends.
    set_presses(16'h7FFF, 32'hFFFF_FFFF);
    set_presses(16'h8000, 32'h0000_0000);
    pin_sample(1'b0, 32'd0);

    // Default timing, negative weight so press_value shows the product.
    c = '{active_high: 1'b0, enable: 1'b1, debounce_ms: 16'd20,
          multi_press_ms: 16'd250, long_press_ms: 16'd1000, button_value: -16'sd3};
    apply_cfg(c);
    set_presses(16'd5, $urandom());
    // single click: press debounces at once, release publishes after 251 ms
    now = 32'd100;
    pin_sample(1'b1, 32'd0);
    pin_sample(1'b1, 32'd21);
    pin_sample(1'b0, 32'd5);
    pin_sample(1'b0, 32'd21);
    pin_sample(1'b0, 32'd251);
    // long press: held reported, then reported again while still held
    pin_sample(1'b1, 32'd10);
    pin_sample(1'b1, 32'd1001);
    pin_sample(1'b1, 32'd5);
    pin_sample(1'b0, 32'd3);
    pin_sample(1'b0, 32'd300);
    // press across the 32-bit timestamp wrap
    now = 32'hFFFF_FFF0;
    pin_sample(1'b1, 32'd0);
    pin_sample(1'b1, 32'h25);
    pin_sample(1'b0, 32'd1);
    pin_sample(1'b0, 32'd300);
    // disabled: samples leave state alone, set-presses still lands
    c.enable = 1'b0;
    apply_cfg(c);
    pin_sample(1'b1, 32'd0);
    pin_sample(1'b1, 32'd500);
    set_presses(16'hFFF7, $urandom());
    pin_sample(1'b0, 32'd20);

    // ---- Random part ----
    run_phase('{active_high: 1'b0, enable: 1'b1, debounce_ms: 16'd20,
                multi_press_ms: 16'd250, long_press_ms: 16'd1000,
                button_value: 16'sd3}, 70);
    // all thresholds at zero, most negative weight
    run_phase('{active_high: 1'b1, enable: 1'b1, debounce_ms: 16'd0,
                multi_press_ms: 16'd0, long_press_ms: 16'd0,
                button_value: 16'h8000}, 60);
    // all thresholds at their maximum, most positive weight
    run_phase('{active_high: 1'b1, enable: 1'b1, debounce_ms: 16'hFFFF,
                multi_press_ms: 16'hFFFF, long_press_ms: 16'hFFFF,
                button_value: 16'h7FFF}, 50);
    // whole phase disabled
    run_phase('{active_high: 1'b0, enable: 1'b0, debounce_ms: 16'd10,
                multi_press_ms: 16'd100, long_press_ms: 16'd300,
                button_value: 16'hFFFF}, 40);
    repeat (3) run_phase(random_cfg(), 60);

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    run_phase(random_cfg(), 50);

    // ---- Wind-down ----
    drain();
    repeat (4) @(posedge clk);
    if (pending != 0) begin
      $error("%0d expected reports never arrived", pending);
      leftover = 1'b1;
    end
    $display("Covered %0d input beats of clicks, long holds, bounce and set-presses",
             beats_sent);
    $display("under %0d settings, with %0d reports compared field by field.",
             settings_done, compared);
    if (fail_count == 0 && !leftover) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d reports outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== button_debounce_multipress.f =====
rtl/bdm_pkg.sv
rtl/bdm_core.sv
rtl/bdm_out.sv
rtl/button_debounce_multipress.sv
rtl/bdm_checker.sv
tb/sv/press_report_checker.sv
tb/sv/button_debounce_multipress_tb.sv
